// File: hdl/rcic_pkg.sv
package rcic_pkg;

  // Configuration register map
  localparam int REG_INDEX_BITS = 2;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_RADIUS       = 2'd0,
    REG_AXIAL_LENGTH = 2'd1,
    REG_EPSILON      = 2'd2
  } reg_index_t;

endpackage

// File: hdl/ray_cylinder_interval_clip_top.sv
// Channel   Handshake           Payload
// -------   ---------           -------
// command   start / busy        org_x org_y org_z dir_x dir_y dir_z interval_min interval_max
// result    done (one cycle)    hit entry_dist exit_dist
// config    wr_en               wr_index wr_data
//
// One ray enters per clock; busy is high only while rst is high.
// The result strobe follows a start transfer through the front stages, the square root
// (SW stages, one root bit each), the divider (QW stages, four lanes) and the clipping tail;
// SW is the square-root stage count and QW the divider stage count, Q16.16 by default.
// Reset clears every valid bit and loads the register reset values; the result side
// takes every strobe, so nothing in the pipeline ever holds.
module ray_cylinder_interval_clip_top
  import rcic_pkg::*;
#(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [WORD_BITS-1:0] org_x,
  input  logic signed [WORD_BITS-1:0] org_y,
  input  logic signed [WORD_BITS-1:0] org_z,
  input  logic signed [FRAC_BITS+1:0] dir_x,
  input  logic signed [FRAC_BITS+1:0] dir_y,
  input  logic signed [FRAC_BITS+1:0] dir_z,
  input  logic signed [WORD_BITS-1:0] interval_min,
  input  logic signed [WORD_BITS-1:0] interval_max,
  output logic                        done,
  output logic                        hit,
  output logic signed [WORD_BITS-1:0] entry_dist,
  output logic signed [WORD_BITS-1:0] exit_dist,
  input  logic                        wr_en,
  input  logic [REG_INDEX_BITS-1:0]   wr_index,
  input  logic [WORD_BITS-2:0]        wr_data
);

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DB   = F + 2;
  localparam int PW   = W + DB;
  localparam int DOTW = PW + 1;
  localparam int BW   = DOTW + 1 - F;
  localparam int S2W  = 2 * W;
  localparam int CW   = S2W + 1 - F;
  localparam int AW   = 2 * DB - F;
  localparam int BBW  = 2 * BW;
  localparam int ACW  = AW + 1 + CW;
  localparam int DW   = (BBW > ACW) ? BBW : ACW;
  localparam int DDW  = DW + 1;
  localparam int SW   = (DW + 1) / 2;
  localparam int NW   = ((BW > SW + 1) ? BW : SW + 1) + 1;
  localparam int QW   = NW + F;
  localparam int DVW  = AW;
  localparam int CMPW = QW + 2;
  localparam logic [W-2:0] ONE_Q = (W-1)'(1) << F;

  typedef struct packed {
    logic         par;
    logic         dyneg;
    logic [DB-1:0] dym;
    logic         n1neg;
    logic [W+F-1:0] n1m;
    logic [W+F-1:0] n2m;
    logic [W-1:0] imin;
    logic [W-1:0] imax;
  } slab_t;

  typedef struct packed {
    logic          miss;
    logic [AW-1:0] a;
    logic [BW-1:0] b;
    logic [DW-1:0] rem;
    logic [SW-1:0] root;
    slab_t         sl;
  } sq_t;

  typedef struct packed {
    logic          miss;
    logic [AW-1:0] a;
    logic [NW-1:0] n0;
    logic [NW-1:0] n1;
    slab_t         sl;
  } ns_t;

  typedef struct packed {
    logic                     miss;
    logic                     par;
    logic [3:0]               neg;
    logic [DVW-1:0]           dsl;
    logic [DVW-1:0]           da;
    logic [3:0][QW-1:0]       n;
    logic [3:0][DVW-1:0]      r;
    logic [W-1:0]             imin;
    logic [W-1:0]             imax;
  } dv_t;

  typedef struct packed {
    logic            miss;
    logic            par;
    logic [CMPW-1:0] lo;
    logic [CMPW-1:0] hi;
    logic [CMPW-1:0] r0;
    logic [CMPW-1:0] r1;
    logic [W-1:0]    imin;
    logic [W-1:0]    imax;
  } tl_t;

  // One restoring division step: returns next remainder and shifted quotient
  function automatic logic [DVW+QW-1:0] div_step(input logic [DVW-1:0] r,
                                                 input logic [QW-1:0]  n,
                                                 input logic [DVW-1:0] d);
    logic [DVW:0] t;
    logic [DVW:0] s;
    logic         ge;
    t = {r, n[QW-1]};
    s = t - {1'b0, d};
    ge = (t >= {1'b0, d});
    div_step = {(ge ? s[DVW-1:0] : t[DVW-1:0]), n[QW-2:0], ge};
  endfunction

  function automatic logic [CMPW-1:0] sx(input logic [W-1:0] v);
    sx = {{(CMPW-W){v[W-1]}}, v};
  endfunction

  function automatic logic [CMPW-1:0] apply_sign(input logic neg, input logic [QW-1:0] m);
    logic [CMPW-1:0] e;
    e = {2'b00, m};
    apply_sign = neg ? (~e + 1'b1) : e;
  endfunction

  function automatic logic sgt(input logic [CMPW-1:0] x, input logic [CMPW-1:0] y);
    sgt = ($signed(x) > $signed(y));
  endfunction

  // Configuration registers
  logic [W-2:0] radius;
  logic [W-2:0] axial_length;
  logic [F-1:0] epsilon;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= ONE_Q;
      axial_length <= ONE_Q;
      epsilon      <= F'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_RADIUS:       radius       <= wr_data;
        REG_AXIAL_LENGTH: axial_length <= wr_data;
        REG_EPSILON:      epsilon      <= wr_data[F-1:0];
        default:          ;
      endcase
    end
  end

  assign busy = rst;

  // Stage 1: capture the command
  logic                 v1;
  logic signed [W-1:0]  px1, py1, pz1, imin1, imax1;
  logic signed [DB-1:0] dx1, dy1, dz1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start & ~busy;
  end

  always_ff @(posedge clk) begin
    px1 <= org_x;  py1 <= org_y;  pz1 <= org_z;
    dx1 <= dir_x;  dy1 <= dir_y;  dz1 <= dir_z;
    imin1 <= interval_min;
    imax1 <= interval_max;
  end

  // Stage 2: products and slab operands
  logic                   v2;
  logic signed [PW-1:0]   pxdx2, pzdz2;
  logic signed [S2W-1:0]  pxx2, pzz2;
  logic signed [2*DB-1:0] dxx2, dzz2;
  logic [2*W-3:0]         r2_2;
  slab_t                  sl2;
  logic [DB-1:0]          dym1;
  logic [W-1:0]           pym1;

  assign dym1 = dy1[DB-1] ? DB'(-dy1) : DB'(dy1);
  assign pym1 = py1[W-1] ? W'(-py1) : W'(py1);

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    pxdx2 <= px1 * dx1;
    pzdz2 <= pz1 * dz1;
    pxx2  <= px1 * px1;
    pzz2  <= pz1 * pz1;
    dxx2  <= dx1 * dx1;
    dzz2  <= dz1 * dz1;
    r2_2  <= radius * radius;
    sl2.par   <= (dy1 == '0) | (dym1 < DB'(epsilon));
    sl2.dyneg <= dy1[DB-1];
    sl2.dym   <= dym1;
    sl2.n1neg <= ~py1[W-1] & (|py1);
    sl2.n1m   <= {pym1, {F{1'b0}}};
    sl2.n2m   <= {1'b0, axial_length, {F{1'b0}}};
    sl2.imin  <= imin1;
    sl2.imax  <= imax1;
  end

  // Stage 3: sums of products
  logic                  v3;
  logic signed [DOTW-1:0] dot3;
  logic [S2W-1:0]        s2_3;
  logic [2*DB:0]         dsq3;
  logic [2*W-3:0]        r2_3;
  slab_t                 sl3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    dot3 <= DOTW'(pxdx2) + DOTW'(pzdz2);
    s2_3 <= $unsigned(pxx2) + $unsigned(pzz2);
    dsq3 <= (2*DB+1)'($unsigned(dxx2)) + (2*DB+1)'($unsigned(dzz2));
    r2_3 <= r2_2;
    sl3  <= sl2;
  end

  // Stage 4: quadratic coefficients and early misses
  logic                  v4, miss4;
  logic [AW-1:0]         a4;
  logic signed [BW-1:0]  b4;
  logic signed [CW-1:0]  c4;
  slab_t                 sl4;
  logic signed [S2W:0]   diff3;
  logic [DOTW:0]         nd3;
  logic                  far3;

  assign diff3 = $signed({1'b0, s2_3}) - $signed({3'b000, r2_3});
  assign nd3   = -{dot3[DOTW-1], dot3};
  assign far3  = ~diff3[S2W] & (|diff3) & ~dot3[DOTW-1] & (|dot3);

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
  end

  always_ff @(posedge clk) begin
    a4    <= dsq3[F+AW-1:F];
    b4    <= nd3[DOTW:F];
    c4    <= diff3[S2W:F];
    miss4 <= far3 | (dsq3[F+AW-1:F] == '0);
    sl4   <= sl3;
  end

  // Stage 5: b*b and a*c
  logic                  v5, miss5;
  logic [AW-1:0]         a5;
  logic [BW-1:0]         b5;
  logic signed [BBW-1:0] bb5;
  logic signed [ACW-1:0] ac5;
  slab_t                 sl5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
  end

  always_ff @(posedge clk) begin
    bb5   <= b4 * b4;
    ac5   <= $signed({1'b0, a4}) * c4;
    a5    <= a4;
    b5    <= b4;
    miss5 <= miss4;
    sl5   <= sl4;
  end

  // Stage 6: discriminant
  logic                  v6, miss6;
  logic [AW-1:0]         a6;
  logic [BW-1:0]         b6;
  logic signed [DDW-1:0] dd6;
  slab_t                 sl6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
  end

  always_ff @(posedge clk) begin
    dd6   <= DDW'(bb5) - DDW'(ac5);
    a6    <= a5;
    b6    <= b5;
    miss6 <= miss5;
    sl6   <= sl5;
  end

  // Square root pipeline, one root bit per stage; entry applies the epsilon test
  sq_t  sq  [0:SW];
  logic sqv [0:SW];
  logic signed [DDW-1:0] eps_w;

  assign eps_w = $signed({{(DDW-2*F){1'b0}}, epsilon, {F{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) sqv[0] <= 1'b0;
    else     sqv[0] <= v6;
  end

  always_ff @(posedge clk) begin
    sq[0].miss <= miss6 | (dd6 < eps_w);
    sq[0].a    <= a6;
    sq[0].b    <= b6;
    sq[0].rem  <= dd6[DW-1:0];
    sq[0].root <= '0;
    sq[0].sl   <= sl6;
  end

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    localparam int I = SW - 1 - k;
    logic [DW:0] trial;
    logic        take;

    assign trial = ((DW+1)'(sq[k].root) << (I + 1)) | ((DW+1)'(1) << (2 * I));
    assign take  = (trial <= {1'b0, sq[k].rem});

    always_ff @(posedge clk) begin
      if (rst) sqv[k+1] <= 1'b0;
      else     sqv[k+1] <= sqv[k];
    end

    // Advance the root by one bit
    always_ff @(posedge clk) begin
      sq[k+1].miss <= sq[k].miss;
      sq[k+1].a    <= sq[k].a;
      sq[k+1].b    <= sq[k].b;
      sq[k+1].sl   <= sq[k].sl;
      sq[k+1].rem  <= take ? (sq[k].rem - trial[DW-1:0]) : sq[k].rem;
      sq[k+1].root <= take ? (sq[k].root | (SW'(1) << I)) : sq[k].root;
    end
  end

  // Root numerators b - s and b + s
  ns_t  ns;
  logic nsv;

  always_ff @(posedge clk) begin
    if (rst) nsv <= 1'b0;
    else     nsv <= sqv[SW];
  end

  always_ff @(posedge clk) begin
    ns.miss <= sq[SW].miss;
    ns.a    <= sq[SW].a;
    ns.n0   <= NW'($signed(sq[SW].b)) - NW'($signed({1'b0, sq[SW].root}));
    ns.n1   <= NW'($signed(sq[SW].b)) + NW'($signed({1'b0, sq[SW].root}));
    ns.sl   <= sq[SW].sl;
  end

  // Divider pipeline: lanes 0,1 slab distances over |dir_y|, lanes 2,3 roots over a
  dv_t  dv  [0:QW];
  logic dvv [0:QW];
  logic [NW-1:0] m0, m1;

  assign m0 = ns.n0[NW-1] ? (~ns.n0 + 1'b1) : ns.n0;
  assign m1 = ns.n1[NW-1] ? (~ns.n1 + 1'b1) : ns.n1;

  always_ff @(posedge clk) begin
    if (rst) dvv[0] <= 1'b0;
    else     dvv[0] <= nsv;
  end

  always_ff @(posedge clk) begin
    dv[0].miss <= ns.miss;
    dv[0].par  <= ns.sl.par;
    dv[0].neg  <= {ns.n1[NW-1], ns.n0[NW-1], ns.sl.dyneg, ns.sl.n1neg ^ ns.sl.dyneg};
    dv[0].dsl  <= DVW'(ns.sl.dym);
    dv[0].da   <= ns.a;
    dv[0].n[0] <= QW'(ns.sl.n1m);
    dv[0].n[1] <= QW'(ns.sl.n2m);
    dv[0].n[2] <= {m0, {F{1'b0}}};
    dv[0].n[3] <= {m1, {F{1'b0}}};
    dv[0].r    <= '0;
    dv[0].imin <= ns.sl.imin;
    dv[0].imax <= ns.sl.imax;
  end

  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [3:0][DVW+QW-1:0] st;

    for (genvar j = 0; j < 4; j++) begin : g_lane
      assign st[j] = div_step(dv[k].r[j], dv[k].n[j], (j < 2) ? dv[k].dsl : dv[k].da);
    end

    always_ff @(posedge clk) begin
      if (rst) dvv[k+1] <= 1'b0;
      else     dvv[k+1] <= dvv[k];
    end

    // Shift one quotient bit into each lane
    always_ff @(posedge clk) begin
      dv[k+1].miss <= dv[k].miss;
      dv[k+1].par  <= dv[k].par;
      dv[k+1].neg  <= dv[k].neg;
      dv[k+1].dsl  <= dv[k].dsl;
      dv[k+1].da   <= dv[k].da;
      dv[k+1].imin <= dv[k].imin;
      dv[k+1].imax <= dv[k].imax;
      for (int j = 0; j < 4; j++) begin
        dv[k+1].r[j] <= st[j][DVW+QW-1:QW];
        dv[k+1].n[j] <= st[j][QW-1:0];
      end
    end
  end

  // Tail: sign the quotients, then clip the interval step by step
  tl_t  p1, p2, p3, p4, p5, p6;
  logic pv1, pv2, pv3, pv4, pv5, pv6;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv1 <= 1'b0; pv2 <= 1'b0; pv3 <= 1'b0;
      pv4 <= 1'b0; pv5 <= 1'b0; pv6 <= 1'b0;
    end else begin
      pv1 <= dvv[QW]; pv2 <= pv1; pv3 <= pv2;
      pv4 <= pv3;     pv5 <= pv4; pv6 <= pv5;
    end
  end

  // Signed quotients; lo holds the near cap distance, hi the cap span for now
  always_ff @(posedge clk) begin
    p1.miss <= dv[QW].miss;
    p1.par  <= dv[QW].par;
    p1.lo   <= apply_sign(dv[QW].neg[0], dv[QW].n[0]);
    p1.hi   <= apply_sign(dv[QW].neg[1], dv[QW].n[1]);
    p1.r0   <= apply_sign(dv[QW].neg[2], dv[QW].n[2]);
    p1.r1   <= apply_sign(dv[QW].neg[3], dv[QW].n[3]);
    p1.imin <= dv[QW].imin;
    p1.imax <= dv[QW].imax;
  end

  // Far cap distance
  always_ff @(posedge clk) begin
    p2.miss <= p1.miss;
    p2.par  <= p1.par;
    p2.lo   <= p1.lo;
    p2.hi   <= p1.lo + p1.hi;
    p2.r0   <= p1.r0;
    p2.r1   <= p1.r1;
    p2.imin <= p1.imin;
    p2.imax <= p1.imax;
  end

  // Order the cap distances
  always_ff @(posedge clk) begin
    p3.miss <= p2.miss;
    p3.par  <= p2.par;
    p3.lo   <= sgt(p2.lo, p2.hi) ? p2.hi : p2.lo;
    p3.hi   <= sgt(p2.lo, p2.hi) ? p2.lo : p2.hi;
    p3.r0   <= p2.r0;
    p3.r1   <= p2.r1;
    p3.imin <= p2.imin;
    p3.imax <= p2.imax;
  end

  // Clip the cap span to the interval, or pass the interval when parallel
  always_ff @(posedge clk) begin
    p4.par  <= p3.par;
    p4.r0   <= p3.r0;
    p4.r1   <= p3.r1;
    p4.imin <= p3.imin;
    p4.imax <= p3.imax;
    if (p3.par) begin
      p4.miss <= p3.miss;
      p4.lo   <= sx(p3.imin);
      p4.hi   <= sx(p3.imax);
    end else begin
      p4.miss <= p3.miss | sgt(p3.lo, sx(p3.imax)) | sgt(sx(p3.imin), p3.hi);
      p4.lo   <= sgt(sx(p3.imin), p3.lo) ? sx(p3.imin) : p3.lo;
      p4.hi   <= sgt(p3.hi, sx(p3.imax)) ? sx(p3.imax) : p3.hi;
    end
  end

  // Near wall root
  always_ff @(posedge clk) begin
    p5.par  <= p4.par;
    p5.hi   <= p4.hi;
    p5.r0   <= p4.r0;
    p5.r1   <= p4.r1;
    p5.imin <= p4.imin;
    p5.imax <= p4.imax;
    p5.miss <= p4.miss | sgt(p4.r0, p4.hi);
    p5.lo   <= sgt(p4.r0, p4.lo) ? p4.r0 : p4.lo;
  end

  // Far wall root
  always_ff @(posedge clk) begin
    p6.par  <= p5.par;
    p6.lo   <= p5.lo;
    p6.r0   <= p5.r0;
    p6.r1   <= p5.r1;
    p6.imin <= p5.imin;
    p6.imax <= p5.imax;
    p6.miss <= p5.miss | sgt(p5.lo, p5.r1);
    p6.hi   <= sgt(p5.hi, p5.r1) ? p5.r1 : p5.hi;
  end

  // Result register; drop the interval on a miss
  logic miss_out;

  assign miss_out = p6.miss | sgt(p6.lo, p6.hi);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= pv6;
  end

  always_ff @(posedge clk) begin
    hit        <= ~miss_out;
    entry_dist <= miss_out ? '0 : $signed(p6.lo[W-1:0]);
    exit_dist  <= miss_out ? '0 : $signed(p6.hi[W-1:0]);
  end

endmodule
